/* rtl/gwp_pkg.sv */
// ---------------------------------------------------------------------------
// gwp_pkg
// Shared types and constants for the grid wireframe projector.
// ---------------------------------------------------------------------------
package gwp_pkg;

  localparam int COORD_BITS = 24;
  localparam int FOCAL_W    = 16;
  localparam int WIDTH_W    = 11;
  localparam int PROD_W     = COORD_BITS + FOCAL_W;
  localparam int MAG_W      = PROD_W - 1;
  localparam int DIV_CNT_W  = $clog2(MAG_W + 1);
  localparam int ADDR_W     = 4;

  localparam int DEF_MAX_ROW_NODES = 1024;

  localparam logic [WIDTH_W-1:0]           RST_GRID_WIDTH   = WIDTH_W'(1);
  localparam logic                         RST_PERSPECTIVE  = 1'b0;
  localparam logic [FOCAL_W-1:0]           RST_FOCAL_LENGTH = FOCAL_W'(1000);
  localparam logic signed [COORD_BITS-1:0] RST_DEPTH_OFFSET = COORD_BITS'(256000);

  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_GRID_WIDTH   = 2'd0,
    REG_PERSPECTIVE  = 2'd1,
    REG_FOCAL_LENGTH = 2'd2,
    REG_DEPTH_OFFSET = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

  typedef struct packed {
    point_t pt;
    logic   has_left;
    logic   has_up;
  } node_t;

  typedef struct packed {
    logic                 persp;
    logic [FOCAL_W-1:0]   focal;
  } proj_cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_FIN,
    S_SEG_L,
    S_SEG_U
  } back_state_t;

endpackage

/* rtl/gwp_queue.sv */
// ---------------------------------------------------------------------------
// gwp_queue
// Two-entry queue between the classifying front end and the projection core.
// ---------------------------------------------------------------------------
module gwp_queue import gwp_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] head
);

  logic [W-1:0] slots [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/gwp_front.sv */
// ---------------------------------------------------------------------------
// gwp_front
// Accepts nodes, applies the depth offset and tracks column and first row.
// ---------------------------------------------------------------------------
module gwp_front import gwp_pkg::*; #(
  parameter int MAX_ROW_NODES = DEF_MAX_ROW_NODES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  node_x,
  input  logic signed [COORD_BITS-1:0]  node_y,
  input  logic signed [COORD_BITS-1:0]  node_z,
  input  logic                          frame_last,
  input  logic [WIDTH_W-1:0]            grid_width,
  input  logic signed [COORD_BITS-1:0]  depth_offset,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [$clog2(MAX_ROW_NODES)-1:0] q_col,
  output node_t                         q_node
);

  localparam int CNT_W = $clog2(MAX_ROW_NODES);
  localparam int CMP_W = (CNT_W + 2 > WIDTH_W + 1) ? CNT_W + 2 : WIDTH_W + 1;

  logic [CNT_W-1:0]             column_count;
  logic                         first_row;
  logic [CMP_W-1:0]             w_raw;
  logic [CMP_W-1:0]             w_eff;
  logic                         row_end;
  logic signed [COORD_BITS:0]   z_sum;
  logic signed [COORD_BITS-1:0] z_sat;

  assign in_ready = ~q_full;
  assign q_push   = in_valid & ~q_full;

  always_comb begin
    w_raw = CMP_W'(grid_width);
    if (w_raw == '0) begin
      w_eff = CMP_W'(1);
    end else if (w_raw > CMP_W'(MAX_ROW_NODES)) begin
      w_eff = CMP_W'(MAX_ROW_NODES);
    end else begin
      w_eff = w_raw;
    end
    row_end = (CMP_W'(column_count) + CMP_W'(1)) >= w_eff;
  end

  always_comb begin
    z_sum = {node_z[COORD_BITS-1], node_z} + {depth_offset[COORD_BITS-1], depth_offset};
    if (z_sum > (COORD_BITS+1)'(CMAX)) begin
      z_sat = CMAX;
    end else if (z_sum < $signed({CMIN[COORD_BITS-1], CMIN})) begin
      z_sat = CMIN;
    end else begin
      z_sat = z_sum[COORD_BITS-1:0];
    end
  end

  assign q_col             = column_count;
  assign q_node.pt.x       = node_x;
  assign q_node.pt.y       = node_y;
  assign q_node.pt.z       = z_sat;
  assign q_node.has_left   = (column_count != '0);
  assign q_node.has_up     = ~first_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      first_row    <= 1'b1;
    end else if (q_push) begin
      if (frame_last) begin
        column_count <= '0;
        first_row    <= 1'b1;
      end else if (row_end) begin
        column_count <= '0;
        first_row    <= 1'b0;
      end else begin
        column_count <= column_count + CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/gwp_back.sv */
// ---------------------------------------------------------------------------
// gwp_back
// Projects one node with a bit-serial divider and emits its segments.
// ---------------------------------------------------------------------------
module gwp_back import gwp_pkg::*; #(
  parameter int MAX_ROW_NODES = DEF_MAX_ROW_NODES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  proj_cfg_t                     cfg,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic [$clog2(MAX_ROW_NODES)-1:0] q_col,
  input  node_t                         q_node,
  output logic                          out_valid,
  input  logic                          out_ready,
  output point_t                        seg_start,
  output point_t                        seg_stop,
  output logic                          edge_vertical,
  output logic                          run_last
);

  localparam int CNT_W = $clog2(MAX_ROW_NODES);

  back_state_t state, state_next;

  point_t                    row_store [MAX_ROW_NODES];
  point_t                    up_pt;
  point_t                    left_node;
  point_t                    left_prev;
  point_t                    cur;
  node_t                     node;
  logic [CNT_W-1:0]          col;

  logic signed [PROD_W-1:0]  px;
  logic signed [PROD_W-1:0]  py;
  logic [COORD_BITS-1:0]     zmag;
  logic                      zneg;
  logic [MAG_W-1:0]          dvd_x;
  logic [MAG_W-1:0]          dvd_y;
  logic [COORD_BITS-1:0]     rem_x;
  logic [COORD_BITS-1:0]     rem_y;
  logic [DIV_CNT_W-1:0]      div_cnt;

  logic [COORD_BITS:0]       sh_x;
  logic [COORD_BITS:0]       sh_y;
  logic                      qb_x;
  logic                      qb_y;
  logic [COORD_BITS:0]       dif_x;
  logic [COORD_BITS:0]       dif_y;
  logic signed [COORD_BITS-1:0] proj_x;
  logic signed [COORD_BITS-1:0] proj_y;
  logic                      load_out;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] a;
    a = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    return a[MAG_W-1:0];
  endfunction

  // sign fix and saturation of a magnitude quotient
  function automatic logic signed [COORD_BITS-1:0] finish(
    input logic signed [PROD_W-1:0] p,
    input logic                     zn,
    input logic                     zzero,
    input logic [MAG_W-1:0]         q
  );
    logic neg;
    logic [MAG_W-1:0] lim_pos;
    logic [MAG_W-1:0] lim_neg;
    logic signed [COORD_BITS-1:0] r;
    neg     = p[PROD_W-1] ^ zn;
    lim_pos = MAG_W'(CMAX);
    lim_neg = MAG_W'(1) << (COORD_BITS - 1);
    if (zzero) begin
      if (p == '0)             r = '0;
      else if (p[PROD_W-1])    r = CMIN;
      else                     r = CMAX;
    end else if (!neg) begin
      r = (q > lim_pos) ? CMAX : q[COORD_BITS-1:0];
    end else begin
      r = (q > lim_neg) ? CMIN : COORD_BITS'(-q[COORD_BITS-1:0]);
    end
    return r;
  endfunction

  always_comb begin
    sh_x  = {rem_x, dvd_x[MAG_W-1]};
    sh_y  = {rem_y, dvd_y[MAG_W-1]};
    dif_x = sh_x - {1'b0, zmag};
    dif_y = sh_y - {1'b0, zmag};
    qb_x  = sh_x >= {1'b0, zmag};
    qb_y  = sh_y >= {1'b0, zmag};
    proj_x = finish(px, zneg, zmag == '0, dvd_x);
    proj_y = finish(py, zneg, zmag == '0, dvd_y);
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL:  state_next = S_LOAD;
      S_LOAD: state_next = (cfg.persp && zmag != '0) ? S_DIV : S_FIN;
      S_DIV:  state_next = (div_cnt == DIV_CNT_W'(MAG_W - 1)) ? S_FIN : S_DIV;
      S_FIN: begin
        if (node.has_left)    state_next = S_SEG_L;
        else if (node.has_up) state_next = S_SEG_U;
        else                  state_next = S_IDLE;
      end
      S_SEG_L: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = node.has_up ? S_SEG_U : S_IDLE;
        end
      end
      S_SEG_U: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // row buffer, read when the node is taken, written once it is projected
  always_ff @(posedge clk) begin
    if (q_pop) begin
      up_pt <= row_store[q_col];
    end
    if (state == S_FIN) begin
      row_store[col] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        node <= q_node;
        col  <= q_col;
      end
      S_MUL: begin
        px   <= node.pt.x * $signed({1'b0, cfg.focal});
        py   <= node.pt.y * $signed({1'b0, cfg.focal});
        zneg <= node.pt.z[COORD_BITS-1];
        zmag <= node.pt.z[COORD_BITS-1] ? COORD_BITS'(-node.pt.z) : node.pt.z;
      end
      S_LOAD: begin
        dvd_x   <= mag_of(px);
        dvd_y   <= mag_of(py);
        rem_x   <= '0;
        rem_y   <= '0;
        div_cnt <= '0;
      end
      S_DIV: begin
        rem_x   <= qb_x ? dif_x[COORD_BITS-1:0] : sh_x[COORD_BITS-1:0];
        rem_y   <= qb_y ? dif_y[COORD_BITS-1:0] : sh_y[COORD_BITS-1:0];
        dvd_x   <= {dvd_x[MAG_W-2:0], qb_x};
        dvd_y   <= {dvd_y[MAG_W-2:0], qb_y};
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cur.z = node.pt.z;
    if (cfg.persp) begin
      cur.x = proj_x;
      cur.y = proj_y;
    end else begin
      cur.x = node.pt.x;
      cur.y = node.pt.y;
    end
  end

  point_t cur_q;

  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      cur_q     <= cur;
      left_prev <= left_node;
      left_node <= cur;
    end
    if (load_out) begin
      seg_stop <= cur_q;
      if (state == S_SEG_L) begin
        seg_start     <= left_prev;
        edge_vertical <= 1'b0;
        run_last      <= ~node.has_up;
      end else begin
        seg_start     <= up_pt;
        edge_vertical <= 1'b1;
        run_last      <= 1'b1;
      end
    end
  end

endmodule

/* rtl/grid_wireframe_projector_unit.sv */
// nodes are projected one at a time: the back end takes no new node until it has
// handed the last one's segments to the output register; perspective mode uses a
// 39-step serial divider, and each node gives zero, one or two segments
// reset: synchronous, active high; clears control state and loads register
// defaults; the row buffer holds no meaning until a full row has been written
// ---------------------------------------------------------------------------
// grid_wireframe_projector_unit
// Projects height grid nodes and emits wireframe line segments per node.
// ---------------------------------------------------------------------------
module grid_wireframe_projector_unit import gwp_pkg::*; #(
  parameter int MAX_ROW_NODES = DEF_MAX_ROW_NODES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  node_x,
  input  logic signed [COORD_BITS-1:0]  node_y,
  input  logic signed [COORD_BITS-1:0]  node_z,
  input  logic                          frame_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_BITS-1:0]  start_x,
  output logic signed [COORD_BITS-1:0]  start_y,
  output logic signed [COORD_BITS-1:0]  start_z,
  output logic signed [COORD_BITS-1:0]  stop_x,
  output logic signed [COORD_BITS-1:0]  stop_y,
  output logic signed [COORD_BITS-1:0]  stop_z,
  output logic                          edge_vertical,
  output logic                          run_last
);

  localparam int CNT_W = $clog2(MAX_ROW_NODES);
  localparam int QW    = CNT_W + $bits(node_t);

  logic [WIDTH_W-1:0]           grid_width;
  logic                         perspective_on;
  logic [FOCAL_W-1:0]           focal_length;
  logic signed [COORD_BITS-1:0] depth_offset;
  reg_idx_t                     ridx;
  logic                         wr_en;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= RST_GRID_WIDTH;
      perspective_on <= RST_PERSPECTIVE;
      focal_length   <= RST_FOCAL_LENGTH;
      depth_offset   <= RST_DEPTH_OFFSET;
    end else if (wr_en) begin
      case (ridx)
        REG_GRID_WIDTH:   grid_width     <= pwdata[WIDTH_W-1:0];
        REG_PERSPECTIVE:  perspective_on <= pwdata[0];
        REG_FOCAL_LENGTH: focal_length   <= pwdata[FOCAL_W-1:0];
        REG_DEPTH_OFFSET: depth_offset   <= pwdata[COORD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_GRID_WIDTH:   prdata = 32'(grid_width);
      REG_PERSPECTIVE:  prdata = 32'(perspective_on);
      REG_FOCAL_LENGTH: prdata = 32'(focal_length);
      REG_DEPTH_OFFSET: prdata = 32'(depth_offset);
      default:          prdata = '0;
    endcase
  end

  logic             q_full;
  logic             q_push;
  logic [CNT_W-1:0] f_col;
  node_t            f_node;
  logic             q_pop;
  logic             q_valid;
  logic [QW-1:0]    q_head;
  proj_cfg_t        pcfg;
  point_t           seg_start;
  point_t           seg_stop;

  gwp_front #(.MAX_ROW_NODES(MAX_ROW_NODES)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .node_x       (node_x),
    .node_y       (node_y),
    .node_z       (node_z),
    .frame_last   (frame_last),
    .grid_width   (grid_width),
    .depth_offset (depth_offset),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_col        (f_col),
    .q_node       (f_node)
  );

  gwp_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_col, f_node}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  assign pcfg.persp = perspective_on;
  assign pcfg.focal = focal_length;

  gwp_back #(.MAX_ROW_NODES(MAX_ROW_NODES)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (pcfg),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_col         (q_head[QW-1 -: CNT_W]),
    .q_node        (q_head[$bits(node_t)-1:0]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .seg_start     (seg_start),
    .seg_stop      (seg_stop),
    .edge_vertical (edge_vertical),
    .run_last      (run_last)
  );

  assign start_x = seg_start.x;
  assign start_y = seg_start.y;
  assign start_z = seg_start.z;
  assign stop_x  = seg_stop.x;
  assign stop_y  = seg_stop.y;
  assign stop_z  = seg_stop.z;

endmodule

/* tb/tb_grid_wireframe_projector_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_grid_wireframe_projector_unit
// Self-checking bench for the grid wireframe projector. Grid nodes are sent
// map by map under several register settings; a scoreboard predicts the
// projected line segments and checks every output beat field by field.
// ---------------------------------------------------------------------------
module tb_grid_wireframe_projector_unit;
  import gwp_pkg::*;

  localparam int ROW_NODES  = 1024;
  localparam int STALL_MAX  = 6000;
  localparam int DRAIN_WAIT = 60;

  typedef struct {
    point_t from_pt;
    point_t to_pt;
    bit     vert;
    bit     fin;
  } segment_t;

  class segment_board;
    point_t      row_mem[ROW_NODES];
    int unsigned col;
    bit          first_row;
    point_t      left_pt;
    int unsigned width_reg;
    bit          persp_reg;
    longint      focal_reg;
    longint      offset_reg;
    segment_t    segments_due[$];
    int          errors;
    int          segs_checked;

    function new();
      col = 0;
      first_row = 1;
      width_reg = 1;
      persp_reg = 0;
      focal_reg = 1000;
      offset_reg = 256000;
      errors = 0;
      segs_checked = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_GRID_WIDTH:   width_reg = v[WIDTH_W-1:0];
        REG_PERSPECTIVE:  persp_reg = v[0];
        REG_FOCAL_LENGTH: focal_reg = longint'(v[FOCAL_W-1:0]);
        REG_DEPTH_OFFSET: offset_reg = longint'($signed(v[COORD_BITS-1:0]));
        default: ;
      endcase
    endfunction

    function longint clamp(longint v);
      if (v > longint'(CMAX)) return longint'(CMAX);
      if (v < longint'(CMIN)) return longint'(CMIN);
      return v;
    endfunction

    function longint scale(longint c, longint zd);
      longint p;
      p = c * focal_reg;
      if (zd == 0) begin
        if (p > 0) return longint'(CMAX);
        if (p < 0) return longint'(CMIN);
        return 0;
      end
      return clamp(p / zd);
    endfunction

    function void note_node(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
                            logic signed [COORD_BITS-1:0] z, bit fl);
      point_t      cur;
      segment_t    s;
      longint      zo;
      int unsigned w;
      w = (width_reg == 0) ? 1 : (width_reg > ROW_NODES ? ROW_NODES : width_reg);
      zo = clamp(longint'(z) + offset_reg);
      cur.z = zo[COORD_BITS-1:0];
      if (persp_reg) begin
        cur.x = COORD_BITS'(scale(longint'(x), zo));
        cur.y = COORD_BITS'(scale(longint'(y), zo));
      end else begin
        cur.x = x;
        cur.y = y;
      end
      if (col > 0) begin
        s.from_pt = left_pt;
        s.to_pt = cur;
        s.vert = 0;
        s.fin = first_row;
        segments_due.push_back(s);
      end
      if (!first_row) begin
        s.from_pt = row_mem[col];
        s.to_pt = cur;
        s.vert = 1;
        s.fin = 1;
        segments_due.push_back(s);
      end
      row_mem[col] = cur;
      left_pt = cur;
      if (col + 1 >= w) begin
        col = 0;
        first_row = 0;
      end else begin
        col++;
      end
      if (fl) begin
        col = 0;
        first_row = 1;
      end
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      if (errors <= 20)
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task check_segment(segment_t got);
      segment_t want;
      segs_checked++;
      if (segments_due.size() == 0) begin
        report("unexpected segment", 1, 0);
      end else begin
        want = segments_due.pop_front();
        if (got.from_pt.x !== want.from_pt.x) report("start_x", got.from_pt.x, want.from_pt.x);
        if (got.from_pt.y !== want.from_pt.y) report("start_y", got.from_pt.y, want.from_pt.y);
        if (got.from_pt.z !== want.from_pt.z) report("start_z", got.from_pt.z, want.from_pt.z);
        if (got.to_pt.x !== want.to_pt.x) report("stop_x", got.to_pt.x, want.to_pt.x);
        if (got.to_pt.y !== want.to_pt.y) report("stop_y", got.to_pt.y, want.to_pt.y);
        if (got.to_pt.z !== want.to_pt.z) report("stop_z", got.to_pt.z, want.to_pt.z);
        if (got.vert !== want.vert) report("edge_vertical", got.vert, want.vert);
        if (got.fin !== want.fin) report("run_last", got.fin, want.fin);
      end
    endtask
  endclass

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [ADDR_W-1:0]            paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [COORD_BITS-1:0] node_x;
  logic signed [COORD_BITS-1:0] node_y;
  logic signed [COORD_BITS-1:0] node_z;
  logic                         frame_last;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] start_z;
  logic signed [COORD_BITS-1:0] stop_x;
  logic signed [COORD_BITS-1:0] stop_y;
  logic signed [COORD_BITS-1:0] stop_z;
  logic                         edge_vertical;
  logic                         run_last;

  grid_wireframe_projector_unit u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .node_x(node_x), .node_y(node_y), .node_z(node_z), .frame_last(frame_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .stop_x(stop_x), .stop_y(stop_y), .stop_z(stop_z),
    .edge_vertical(edge_vertical), .run_last(run_last)
  );

  segment_board board = new();
  int unsigned  tx_idle_pct;
  int unsigned  rx_idle_pct;
  bit           rx_hold;
  int           stall_cycles;
  int           nodes_sent;
  int           phases_run;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receive side: check beats and pick the next ready
  always @(posedge clk) begin
    segment_t got;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.from_pt = '{start_x, start_y, start_z};
        got.to_pt = '{stop_x, stop_y, stop_z};
        got.vert = edge_vertical;
        got.fin = run_last;
        board.check_segment(got);
      end
      out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("watchdog: no beat for %0d cycles", stall_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task write_reg(reg_idx_t idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx));
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_reg(idx, v);
  endtask

  task set_config(int unsigned w, bit p, int unsigned f, int off);
    write_reg(REG_GRID_WIDTH, 32'(w));
    write_reg(REG_PERSPECTIVE, 32'(p));
    write_reg(REG_FOCAL_LENGTH, 32'(f));
    write_reg(REG_DEPTH_OFFSET, 32'(off));
  endtask

  // valid stays high across back-to-back beats; dropped only for a gap
  task send_node(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
                 logic signed [COORD_BITS-1:0] z, bit fl);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    node_x <= x;
    node_y <= y;
    node_z <= z;
    frame_last <= fl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_node(x, y, z, fl);
    nodes_sent++;
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.segments_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function logic signed [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(9))
      0: return CMAX;
      1: return CMIN;
      2: return '0;
      3, 4, 5: return COORD_BITS'(int'($urandom_range(8191)) - 4096);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function logic signed [COORD_BITS-1:0] pick_depth();
    longint neg_off;
    neg_off = -board.offset_reg;
    // hit the zero divisor now and then
    if ($urandom_range(7) == 0 && neg_off <= longint'(CMAX))
      return COORD_BITS'(neg_off);
    return pick_coord();
  endfunction

  // maps of whole rows with random content, some cut short at random
  task random_phase(int unsigned w, bit p, int unsigned f, int off, int count);
    int unsigned weff;
    int          map_len;
    int          i;
    int          left_cnt;
    drain();
    set_config(w, p, f, off);
    phases_run++;
    weff = (w == 0) ? 1 : (w > ROW_NODES ? ROW_NODES : w);
    left_cnt = count;
    while (left_cnt > 0) begin
      if ($urandom_range(9) == 0)
        map_len = $urandom_range(1, 3 * weff);
      else
        map_len = weff * $urandom_range(1, 5);
      if (map_len > left_cnt) map_len = left_cnt;
      for (i = 0; i < map_len; i++)
        send_node(pick_coord(), pick_coord(), pick_depth(), i == map_len - 1);
      left_cnt -= map_len;
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    node_x = '0;
    node_y = '0;
    node_z = '0;
    frame_last = 1'b0;
    rx_hold = 1'b0;
    tx_idle_pct = 18;
    rx_idle_pct = 48;
    nodes_sent = 0;
    phases_run = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero divisor for each sign, saturation and the extremes
    set_config(3, 1'b1, 1000, 0);
    send_node(CMAX, CMIN, '0, 0);
    send_node('0, 24'sd256, '0, 0);
    send_node(CMAX, CMIN, 24'sd1, 0);
    send_node(CMIN, CMAX, CMIN, 0);
    send_node(-24'sd256, 24'sd512, 24'sd256, 0);
    send_node(24'sd1000, -24'sd1000, CMAX, 0);
    send_node(24'sd77, 24'sd5, -24'sd3, 1);
    // zero focal length, zero width, depth offset saturating high
    drain();
    set_config(0, 1'b1, 0, int'(CMAX));
    send_node(CMAX, CMIN, CMAX, 0);
    send_node(24'sd300, -24'sd300, CMIN, 0);
    send_node(24'sd1, 24'sd1, 24'sd1, 1);
    // width beyond the buffer, no divide, offset saturating low
    drain();
    set_config(2047, 1'b0, 65535, int'(CMIN));
    send_node(CMAX, CMAX, CMIN, 0);
    send_node(CMIN, CMIN, CMAX, 0);
    send_node('0, '0, '0, 0);
    send_node(24'sd5, -24'sd5, -24'sd1, 1);
    // mid-row map end and a second map at the same width
    drain();
    set_config(2, 1'b0, 1, 0);
    send_node(24'sd1, 24'sd2, 24'sd3, 0);
    send_node(24'sd4, 24'sd5, 24'sd6, 0);
    send_node(24'sd7, 24'sd8, 24'sd9, 1);
    send_node(24'sd10, 24'sd11, 24'sd12, 0);
    send_node(24'sd13, 24'sd14, 24'sd15, 1);
    drain();

    // receiver holds off while the sender keeps offering nodes
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end
      random_phase(4, 1'b1, 1000, 256000, 160);
    join
    random_phase(1, 1'b0, 1000, 256000, 100);
    tx_idle_pct = 48;
    rx_idle_pct = 18;
    random_phase(7, 1'b1, 65535, int'(COORD_BITS'($urandom)), 160);
    random_phase(40, 1'b0, 1, $urandom_range(65535), 200);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(2, 1'b1, 1, 0, 150);
    random_phase(13, 1'b1, $urandom_range(1, 65535), int'(COORD_BITS'($urandom)), 200);
    random_phase(3, 1'b0, 1000, -256000, 150);
    drain();

    $display("covered %0d nodes in %0d random phases plus directed maps, %0d segments checked",
             nodes_sent, phases_run, board.segs_checked);
    $display("widths 0 to 2047, perspective on and off, zero divisor and zero focal length");
    if (board.errors == 0 && board.segments_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d segments still expected", board.errors,
               board.segments_due.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
